// ===== rtl/nfa_pkg.sv =====
// Shared constants, codes, types and helpers of the NOR flash array model.
// Used by nfa_rem and by the top level nor_flash_array_model; no dependencies.
package nfa_pkg;

  // Array and burst geometry.
  localparam int MEM_BYTES = 65536;
  localparam int MAX_BURST = 64;
  localparam int FLASH_AW  = $clog2(MEM_BYTES);
  localparam int BUF_AW    = $clog2(MAX_BURST);
  // The burst counter must hold MAX_BURST + 1 to mark an overlong burst.
  localparam int CNT_W     = $clog2(MAX_BURST + 2);

  // Field widths of the streams and the register.
  localparam int OP_W     = 3;
  localparam int ADDR_W   = 17;
  localparam int LEN_W    = 17;
  localparam int BYTE_W   = 8;
  localparam int STATUS_W = 3;
  localparam int SECT_W   = 17;
  localparam int IN_DW    = 48;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;

  localparam logic [SECT_W-1:0]  SECTOR_RESET    = SECT_W'(4096);
  localparam logic [BYTE_W-1:0]  ERASED_BYTE     = 8'hFF;
  localparam logic [PADDR_W-1:0] REG_SECTOR_ADDR = 3'h0;

  // Command codes.
  localparam logic [OP_W-1:0] OP_READ   = 3'd0;
  localparam logic [OP_W-1:0] OP_WRITE  = 3'd1;
  localparam logic [OP_W-1:0] OP_ERASE  = 3'd2;
  localparam logic [OP_W-1:0] OP_ARM_EF = 3'd3;
  localparam logic [OP_W-1:0] OP_ARM_WF = 3'd4;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_INJECT = 3'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_ALIGN  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BITSET = 3'd4;
  localparam logic [STATUS_W-1:0] ST_LONG   = 3'd5;

  // Request to and response from the bit-serial remainder unit.
  typedef struct packed {
    logic              start;
    logic [ADDR_W-1:0] dividend;
    logic [SECT_W-1:0] divisor;
  } rem_req_t;

  typedef struct packed {
    logic done;
    logic zero;
  } rem_rsp_t;

  // A range is valid when it starts no later than the end of the array and does not run past that end.
  function automatic logic range_ok(logic [ADDR_W-1:0] addr, logic [LEN_W-1:0] len);
    logic [ADDR_W-1:0] mem_top;
    mem_top = ADDR_W'(MEM_BYTES);
    return (addr <= mem_top) && (len <= (mem_top - addr));
  endfunction

endpackage

// ===== rtl/nor_flash_array_model.sv =====
// NOR flash array model: a 64 KiB byte array behind a command stream and an APB register.
// After reset the array is swept to 0xFF, one byte per cycle; no command word is accepted
// until the sweep ends (the sector register can be written meanwhile). The block works on
// one command at a time on a single flash port with one registered read. A read returns its
// bytes one per result word. A final write byte commits the burst: every byte is read and
// checked, then read again and programmed. An erase checks address and length alignment in
// the bit-serial remainder unit, then fills the range with 0xFF.
// Each result waits in one output register, so a stalled consumer holds the sequencer
// only when a second result is ready.
// Depends on nfa_pkg and nfa_rem.
module nor_flash_array_model (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Command stream.
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // tdata: address [16:0], length [33:17], write_byte [41:34], zero fill [47:42]
  input  logic [nfa_pkg::IN_DW-1:0]     s_axis_tdata,
  // tuser: op [2:0]
  input  logic [nfa_pkg::OP_W-1:0]      s_axis_tuser,
  input  logic                          s_axis_tlast,
  // Result stream.
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // tdata: read_byte [7:0]
  output logic [nfa_pkg::BYTE_W-1:0]    m_axis_tdata,
  // tuser: status [2:0]
  output logic [nfa_pkg::STATUS_W-1:0]  m_axis_tuser,
  output logic                          m_axis_tlast,
  // Register port.
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [nfa_pkg::PADDR_W-1:0]   paddr,
  input  logic [nfa_pkg::PDATA_W-1:0]   pwdata,
  output logic [nfa_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);

  typedef enum logic [13:0] {
    S_CLEAR    = 14'b00000000000001,
    S_IDLE     = 14'b00000000000010,
    S_DISPATCH = 14'b00000000000100,
    S_EMIT     = 14'b00000000001000,
    S_RD_ADDR  = 14'b00000000010000,
    S_RD_DATA  = 14'b00000000100000,
    S_COMMIT   = 14'b00000001000000,
    S_CHK_RD   = 14'b00000010000000,
    S_CHK_CMP  = 14'b00000100000000,
    S_PRG_RD   = 14'b00001000000000,
    S_PRG_WR   = 14'b00010000000000,
    S_REM_A    = 14'b00100000000000,
    S_REM_L    = 14'b01000000000000,
    S_FILL     = 14'b10000000000000
  } state_e;

  state_e state_q, state_d;

  // Latched command word.
  logic [nfa_pkg::OP_W-1:0]     cmd_op_q;
  logic [nfa_pkg::ADDR_W-1:0]   cmd_addr_q;
  logic [nfa_pkg::LEN_W-1:0]    cmd_len_q;
  logic [nfa_pkg::BYTE_W-1:0]   cmd_byte_q;
  logic                         cmd_end_q;
  logic                         in_acc;

  // Sequencer state.
  logic [nfa_pkg::LEN_W-1:0]    idx_q, idx_d, idx_next;
  logic [nfa_pkg::ADDR_W-1:0]   burst_start_q, burst_start_d;
  logic [nfa_pkg::CNT_W-1:0]    count_q, count_d;
  logic [nfa_pkg::CNT_W-1:0]    wlen_q, wlen_d;
  logic                         efail_q, efail_d;
  logic                         wfail_q, wfail_d;
  logic [nfa_pkg::STATUS_W-1:0] res_status_q, res_status_d;
  logic [nfa_pkg::SECT_W-1:0]   sector_q;
  logic                         wlen_done;

  // Output register.
  logic                         m_valid_q;
  logic [nfa_pkg::STATUS_W-1:0] m_status_q;
  logic [nfa_pkg::BYTE_W-1:0]   m_byte_q;
  logic                         m_last_q;
  logic                         can_emit, emit, emit_last;
  logic [nfa_pkg::STATUS_W-1:0] emit_status;
  logic [nfa_pkg::BYTE_W-1:0]   emit_byte;

  // Flash array and write buffer.
  logic [nfa_pkg::BYTE_W-1:0]   flash_mem [nfa_pkg::MEM_BYTES];
  logic [nfa_pkg::BYTE_W-1:0]   buf_mem   [nfa_pkg::MAX_BURST];
  logic [nfa_pkg::ADDR_W-1:0]   flash_base, flash_addr_full;
  logic [nfa_pkg::FLASH_AW-1:0] flash_addr;
  logic                         flash_we;
  logic [nfa_pkg::BYTE_W-1:0]   flash_wdata, flash_rd_q;
  logic                         buf_we;
  logic [nfa_pkg::BYTE_W-1:0]   buf_rd_q;

  nfa_pkg::rem_req_t rem_req;
  nfa_pkg::rem_rsp_t rem_rsp;

  logic cfg_we;

  nfa_rem u_rem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (rem_req),
    .rsp_o  (rem_rsp)
  );

  // ---------------------------------------------------------------- register port
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite
               && (paddr[nfa_pkg::PADDR_W-1:2] == nfa_pkg::REG_SECTOR_ADDR[nfa_pkg::PADDR_W-1:2]);

  always_comb begin
    prdata = '0;
    if (paddr[nfa_pkg::PADDR_W-1:2] == nfa_pkg::REG_SECTOR_ADDR[nfa_pkg::PADDR_W-1:2]) begin
      prdata = {{(nfa_pkg::PDATA_W - nfa_pkg::SECT_W){1'b0}}, sector_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sector_q <= nfa_pkg::SECTOR_RESET;
    end else if (cfg_we) begin
      sector_q <= pwdata[nfa_pkg::SECT_W-1:0];
    end
  end

  // ---------------------------------------------------------------- handshakes
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign can_emit      = !m_valid_q || m_axis_tready;

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_byte_q;
  assign m_axis_tuser  = m_status_q;
  assign m_axis_tlast  = m_last_q;

  // ---------------------------------------------------------------- address path
  always_comb begin
    unique case (state_q)
      S_CLEAR:                                  flash_base = '0;
      S_CHK_RD, S_CHK_CMP, S_PRG_RD, S_PRG_WR:  flash_base = burst_start_q;
      default:                                  flash_base = cmd_addr_q;
    endcase
  end

  assign flash_addr_full = flash_base + idx_q;
  assign flash_addr      = flash_addr_full[nfa_pkg::FLASH_AW-1:0];
  assign idx_next        = idx_q + 1'b1;
  assign wlen_done       = (idx_next == nfa_pkg::LEN_W'(wlen_q));

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_d       = state_q;
    idx_d         = idx_q;
    burst_start_d = burst_start_q;
    count_d       = count_q;
    wlen_d        = wlen_q;
    efail_d       = efail_q;
    wfail_d       = wfail_q;
    res_status_d  = res_status_q;
    flash_we      = 1'b0;
    flash_wdata   = nfa_pkg::ERASED_BYTE;
    buf_we        = 1'b0;
    emit          = 1'b0;
    emit_status   = nfa_pkg::ST_OK;
    emit_byte     = '0;
    emit_last     = 1'b1;
    rem_req.start    = 1'b0;
    rem_req.dividend = cmd_addr_q;
    rem_req.divisor  = sector_q;

    unique case (state_q)
      S_CLEAR: begin
        flash_we = 1'b1;
        if (idx_q[nfa_pkg::FLASH_AW-1:0] == '1) begin
          idx_d   = '0;
          state_d = S_IDLE;
        end else begin
          idx_d = idx_next;
        end
      end

      S_IDLE: begin
        if (in_acc) begin
          state_d = S_DISPATCH;
        end
      end

      S_DISPATCH: begin
        idx_d = '0;
        unique case (cmd_op_q)
          nfa_pkg::OP_READ: begin
            if (cmd_len_q > nfa_pkg::LEN_W'(nfa_pkg::MAX_BURST)) begin
              res_status_d = nfa_pkg::ST_LONG;
              state_d      = S_EMIT;
            end else if (!nfa_pkg::range_ok(cmd_addr_q, cmd_len_q)) begin
              res_status_d = nfa_pkg::ST_RANGE;
              state_d      = S_EMIT;
            end else if (cmd_len_q == '0) begin
              res_status_d = nfa_pkg::ST_OK;
              state_d      = S_EMIT;
            end else begin
              state_d = S_RD_ADDR;
            end
          end
          nfa_pkg::OP_WRITE: begin
            if (count_q == '0) begin
              burst_start_d = cmd_addr_q;
            end
            if (count_q < nfa_pkg::CNT_W'(nfa_pkg::MAX_BURST)) begin
              buf_we  = 1'b1;
              count_d = count_q + 1'b1;
            end else begin
              count_d = nfa_pkg::CNT_W'(nfa_pkg::MAX_BURST + 1);
            end
            state_d = cmd_end_q ? S_COMMIT : S_IDLE;
          end
          nfa_pkg::OP_ERASE: begin
            if (efail_q) begin
              efail_d      = 1'b0;
              res_status_d = nfa_pkg::ST_INJECT;
              state_d      = S_EMIT;
            end else if (!nfa_pkg::range_ok(cmd_addr_q, cmd_len_q)) begin
              res_status_d = nfa_pkg::ST_RANGE;
              state_d      = S_EMIT;
            end else if (sector_q == '0) begin
              res_status_d = nfa_pkg::ST_ALIGN;
              state_d      = S_EMIT;
            end else begin
              rem_req.start = 1'b1;
              state_d       = S_REM_A;
            end
          end
          nfa_pkg::OP_ARM_EF: begin
            efail_d      = 1'b1;
            res_status_d = nfa_pkg::ST_OK;
            state_d      = S_EMIT;
          end
          nfa_pkg::OP_ARM_WF: begin
            wfail_d      = 1'b1;
            res_status_d = nfa_pkg::ST_OK;
            state_d      = S_EMIT;
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end

      S_EMIT: begin
        if (can_emit) begin
          emit        = 1'b1;
          emit_status = res_status_q;
          state_d     = S_IDLE;
        end
      end

      S_RD_ADDR: begin
        state_d = S_RD_DATA;
      end

      S_RD_DATA: begin
        if (can_emit) begin
          emit      = 1'b1;
          emit_byte = flash_rd_q;
          emit_last = (idx_next == cmd_len_q);
          idx_d     = idx_next;
          state_d   = emit_last ? S_IDLE : S_RD_ADDR;
        end
      end

      S_COMMIT: begin
        // The burst ends here whatever the outcome; the walks run on wlen_q.
        count_d = '0;
        wlen_d  = count_q;
        idx_d   = '0;
        if (wfail_q) begin
          wfail_d      = 1'b0;
          res_status_d = nfa_pkg::ST_INJECT;
          state_d      = S_EMIT;
        end else if (count_q > nfa_pkg::CNT_W'(nfa_pkg::MAX_BURST)) begin
          res_status_d = nfa_pkg::ST_LONG;
          state_d      = S_EMIT;
        end else if (!nfa_pkg::range_ok(burst_start_q, nfa_pkg::LEN_W'(count_q))) begin
          res_status_d = nfa_pkg::ST_RANGE;
          state_d      = S_EMIT;
        end else begin
          state_d = S_CHK_RD;
        end
      end

      S_CHK_RD: begin
        state_d = S_CHK_CMP;
      end

      S_CHK_CMP: begin
        if ((flash_rd_q & buf_rd_q) != buf_rd_q) begin
          res_status_d = nfa_pkg::ST_BITSET;
          state_d      = S_EMIT;
        end else if (wlen_done) begin
          idx_d   = '0;
          state_d = S_PRG_RD;
        end else begin
          idx_d   = idx_next;
          state_d = S_CHK_RD;
        end
      end

      S_PRG_RD: begin
        state_d = S_PRG_WR;
      end

      S_PRG_WR: begin
        flash_we    = 1'b1;
        flash_wdata = flash_rd_q & buf_rd_q;
        if (wlen_done) begin
          res_status_d = nfa_pkg::ST_OK;
          state_d      = S_EMIT;
        end else begin
          idx_d   = idx_next;
          state_d = S_PRG_RD;
        end
      end

      S_REM_A: begin
        if (rem_rsp.done) begin
          if (!rem_rsp.zero) begin
            res_status_d = nfa_pkg::ST_ALIGN;
            state_d      = S_EMIT;
          end else begin
            rem_req.start    = 1'b1;
            rem_req.dividend = cmd_len_q;
            state_d          = S_REM_L;
          end
        end
      end

      S_REM_L: begin
        if (rem_rsp.done) begin
          if (!rem_rsp.zero) begin
            res_status_d = nfa_pkg::ST_ALIGN;
            state_d      = S_EMIT;
          end else if (cmd_len_q == '0) begin
            res_status_d = nfa_pkg::ST_OK;
            state_d      = S_EMIT;
          end else begin
            idx_d   = '0;
            state_d = S_FILL;
          end
        end
      end

      S_FILL: begin
        flash_we = 1'b1;
        if (idx_next == cmd_len_q) begin
          res_status_d = nfa_pkg::ST_OK;
          state_d      = S_EMIT;
        end else begin
          idx_d = idx_next;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_CLEAR;
      idx_q         <= '0;
      burst_start_q <= '0;
      count_q       <= '0;
      wlen_q        <= '0;
      efail_q       <= 1'b0;
      wfail_q       <= 1'b0;
      res_status_q  <= nfa_pkg::ST_OK;
      m_valid_q     <= 1'b0;
    end else begin
      state_q       <= state_d;
      idx_q         <= idx_d;
      burst_start_q <= burst_start_d;
      count_q       <= count_d;
      wlen_q        <= wlen_d;
      efail_q       <= efail_d;
      wfail_q       <= wfail_d;
      res_status_q  <= res_status_d;
      m_valid_q     <= emit || (m_valid_q && !m_axis_tready);
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_op_q   <= s_axis_tuser;
      cmd_addr_q <= s_axis_tdata[nfa_pkg::ADDR_W-1:0];
      cmd_len_q  <= s_axis_tdata[nfa_pkg::ADDR_W +: nfa_pkg::LEN_W];
      cmd_byte_q <= s_axis_tdata[nfa_pkg::ADDR_W + nfa_pkg::LEN_W +: nfa_pkg::BYTE_W];
      cmd_end_q  <= s_axis_tlast;
    end
    if (emit) begin
      m_status_q <= emit_status;
      m_byte_q   <= emit_byte;
      m_last_q   <= emit_last;
    end
  end

  // ---------------------------------------------------------------- memories
  always_ff @(posedge clk_i) begin
    if (flash_we) begin
      flash_mem[flash_addr] <= flash_wdata;
    end
    flash_rd_q <= flash_mem[flash_addr];
  end

  always_ff @(posedge clk_i) begin
    if (buf_we) begin
      buf_mem[count_q[nfa_pkg::BUF_AW-1:0]] <= cmd_byte_q;
    end
    buf_rd_q <= buf_mem[idx_q[nfa_pkg::BUF_AW-1:0]];
  end

  // ---------------------------------------------------------------- assertions
  a_no_word_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> !m_axis_tvalid)
    else $error("result word present during the erase sweep after reset");

  a_burst_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= nfa_pkg::CNT_W'(nfa_pkg::MAX_BURST + 1))
    else $error("write burst counter out of bounds");

  a_flash_write_states: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flash_we |-> (state_q == S_CLEAR || state_q == S_FILL || state_q == S_PRG_WR))
    else $error("flash written outside a sweep, fill or program step");

  a_rem_done_expected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_rsp.done |-> (state_q == S_REM_A || state_q == S_REM_L))
    else $error("remainder unit finished while no alignment check was waiting");

  a_commit_clears_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_COMMIT) |=> (count_q == '0))
    else $error("write burst not closed by its commit");

endmodule

// ===== rtl/nfa_rem.sv =====
// Bit-serial restoring remainder unit: one dividend bit per cycle.
// Depends on nfa_pkg for widths and the request and response structs.
module nfa_rem (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  nfa_pkg::rem_req_t req_i,
  output nfa_pkg::rem_rsp_t rsp_o
);

  localparam int CNT_W = $clog2(nfa_pkg::ADDR_W);

  logic                       busy_q, busy_d;
  logic                       done_q, done_d;
  logic [CNT_W-1:0]           cnt_q, cnt_d;
  logic [nfa_pkg::ADDR_W-1:0] dvd_q, dvd_d;
  logic [nfa_pkg::SECT_W-1:0] div_q, div_d;
  logic [nfa_pkg::SECT_W-1:0] rem_q, rem_d;
  logic [nfa_pkg::SECT_W:0]   trial;

  // Shift the next dividend bit in and subtract the divisor where it fits.
  assign trial = {rem_q, dvd_q[nfa_pkg::ADDR_W-1]};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    div_d  = div_q;
    rem_d  = rem_q;
    if (busy_q) begin
      dvd_d = {dvd_q[nfa_pkg::ADDR_W-2:0], 1'b0};
      if (trial >= {1'b0, div_q}) begin
        rem_d = nfa_pkg::SECT_W'(trial - {1'b0, div_q});
      end else begin
        rem_d = trial[nfa_pkg::SECT_W-1:0];
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(nfa_pkg::ADDR_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end else if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = req_i.dividend;
      div_d  = req_i.divisor;
      rem_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    div_q <= div_d;
    rem_q <= rem_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.zero = (rem_q == '0);

endmodule
